### rtl/sbe_pkg.sv
`default_nettype none
package sbe_pkg;

    localparam int unsigned DataW  = 64;
    localparam int unsigned LimitW = 11;

    typedef enum logic [7:0] {
        OP_PUSH   = 8'h01,
        OP_LDSTR  = 8'h02,
        OP_LDVAR  = 8'h03,
        OP_STVAR  = 8'h04,
        OP_ADD    = 8'h10,
        OP_SUB    = 8'h11,
        OP_MUL    = 8'h12,
        OP_DIV    = 8'h13,
        OP_MOD    = 8'h14,
        OP_LT     = 8'h15,
        OP_GT     = 8'h16,
        OP_EQ     = 8'h17,
        OP_NEQ    = 8'h18,
        OP_LAND   = 8'h19,
        OP_LOR    = 8'h1A,
        OP_NEG    = 8'h1B,
        OP_LNOT   = 8'h1C,
        OP_BNOT   = 8'h1D,
        OP_SAY    = 8'h20,
        OP_FEEL   = 8'h21,
        OP_RET    = 8'h50,
        OP_JIF    = 8'h60,
        OP_JMP    = 8'h61,
        OP_HALT   = 8'hFF
    } t_opcode;

    localparam logic [1:0] ST_CONT  = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [1:0] ST_BADOP = 2'd3;

    localparam logic [1:0] EK_NONE  = 2'd0;
    localparam logic [1:0] EK_SAY   = 2'd1;
    localparam logic [1:0] EK_FEEL  = 2'd2;
    localparam logic [1:0] EK_STORE = 2'd3;

    localparam logic [LimitW-1:0] LimitReset = 11'd1024;

    typedef struct packed {
        logic [7:0]       opcode;
        logic [DataW-1:0] immediate;
    } t_instr;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       emit_kind;
        logic [DataW-1:0] emit_value;
        logic             branch_taken;
    } t_result;

endpackage
`default_nettype wire

### rtl/sbe_if.sv
`default_nettype none
interface sbe_instr_if;
    logic            valid;
    logic            ready;
    sbe_pkg::t_instr payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sbe_result_if;
    logic             valid;
    logic             ready;
    sbe_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sbe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sbe_pkg::LimitW-1:0]     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/stack_bytecode_executor.sv
`default_nettype none
// Channel    | dir | payload                                       | handshake
// i_instr    | in  | opcode[8], immediate[64]                      | valid/ready
// o_result   | out | status[2], emit_kind[2], emit_value[64], br[1] | valid/ready
// i_cfg      | in  | stack_limit[11]                               | valid/ready
//
// One item at a time. Pops read the stack memory (registered read) one per
// cycle. S_POPB issues the first pop, S_POPA the pop of a for binary ops; mul
// runs in S_DONE (three 32x32 partial products), div/mod in S_DIV (64-step
// restoring divider). The next item is taken back in S_IDLE.
// The result register parts the two sides: an item is taken while a result
// waits, and only its final cycle stalls until the result register frees up.
// Synchronous active-low reset clears depth and control, sets the limit to 1024;
// the stack memory is not cleared (only entries below the depth are ever read).
module stack_bytecode_executor #(
    parameter int unsigned STACK_DEPTH = 1024
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    sbe_instr_if.sink     i_instr,
    sbe_result_if.source  o_result,
    sbe_cfg_if.sink       i_cfg
);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned W  = sbe_pkg::DataW;
    localparam int unsigned HW = W / 2;

    typedef enum logic [2:0] {
        S_IDLE, S_POPB, S_POPA, S_EXEC, S_MUL, S_DIV, S_DONE
    } t_state;

    // stack memory
    logic [W-1:0] r_mem [STACK_DEPTH];
    logic [W-1:0] r_rdata;
    logic         mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    t_state            r_state;
    logic [DW-1:0]     r_depth;
    logic [sbe_pkg::LimitW-1:0] r_limit;
    logic [7:0]        r_op;
    logic [W-1:0]      r_imm, r_a, r_b;
    logic              r_hasb, r_hasa;
    logic [1:0]        r_npop;
    logic              r_out_v;
    sbe_pkg::t_result  r_out;
    logic [W-1:0]      r_quo, r_rem, r_prod;
    logic [6:0]        r_cnt;

    // effective limit: min(stack_limit, STACK_DEPTH)
    logic [31:0] lim32, eff_lim;
    assign lim32   = 32'(r_limit);
    assign eff_lim = (lim32 < 32'(STACK_DEPTH)) ? lim32 : 32'(STACK_DEPTH);

    logic [W-1:0] a_val, b_val;
    assign a_val = r_hasa ? r_a : '0;
    assign b_val = r_hasb ? r_b : '0;

    // op classification
    logic is_bin, is_un;
    always_comb begin
        is_bin = (r_op >= sbe_pkg::OP_ADD) && (r_op <= sbe_pkg::OP_LOR);
        case (r_op)
            sbe_pkg::OP_STVAR, sbe_pkg::OP_NEG, sbe_pkg::OP_LNOT,
            sbe_pkg::OP_BNOT, sbe_pkg::OP_SAY, sbe_pkg::OP_JIF: is_un = 1'b1;
            default: is_un = 1'b0;
        endcase
    end

    // pop address: top of stack
    logic [DW-1:0] dm1;
    assign dm1       = r_depth - DW'(1);
    assign mem_raddr = dm1[AW-1:0];

    // divider step
    logic [W:0]   rem_sh;
    logic         rem_ge;
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign rem_ge = rem_sh >= {1'b0, b_val};

    // multiply: one 32x32 partial product per cycle, low 64 bits kept
    logic [HW-1:0] mul_x, mul_y;
    logic [W-1:0]  mul_p;
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                mul_x = a_val[HW-1:0]; mul_y = b_val[HW-1:0];
            end
            2'd1: begin
                mul_x = a_val[HW-1:0]; mul_y = b_val[W-1:HW];
            end
            default: begin
                mul_x = a_val[W-1:HW]; mul_y = b_val[HW-1:0];
            end
        endcase
    end
    assign mul_p = {{HW{1'b0}}, mul_x} * {{HW{1'b0}}, mul_y};

    // execute: push value, push enable, result
    logic             do_push;
    logic [W-1:0]     push_val;
    sbe_pkg::t_result res;
    always_comb begin
        do_push  = 1'b0;
        push_val = '0;
        res      = '{status: sbe_pkg::ST_CONT, emit_kind: sbe_pkg::EK_NONE,
                     emit_value: '0, branch_taken: 1'b0};
        case (r_op)
            sbe_pkg::OP_PUSH, sbe_pkg::OP_LDVAR: begin
                do_push = 1'b1; push_val = r_imm;
            end
            sbe_pkg::OP_LDSTR: ;
            sbe_pkg::OP_STVAR: begin
                res.emit_kind = sbe_pkg::EK_STORE; res.emit_value = a_val;
            end
            sbe_pkg::OP_ADD: begin do_push = 1'b1; push_val = a_val + b_val; end
            sbe_pkg::OP_SUB: begin do_push = 1'b1; push_val = a_val - b_val; end
            sbe_pkg::OP_MUL: begin do_push = 1'b1; push_val = r_prod; end
            sbe_pkg::OP_DIV, sbe_pkg::OP_MOD: begin
                if (b_val == '0) begin
                    res.status = sbe_pkg::ST_DIV0;
                end else begin
                    do_push  = 1'b1;
                    push_val = (r_op == sbe_pkg::OP_DIV) ? r_quo : r_rem;
                end
            end
            sbe_pkg::OP_LT:   begin do_push = 1'b1; push_val = W'(a_val < b_val); end
            sbe_pkg::OP_GT:   begin do_push = 1'b1; push_val = W'(a_val > b_val); end
            sbe_pkg::OP_EQ:   begin do_push = 1'b1; push_val = W'(a_val == b_val); end
            sbe_pkg::OP_NEQ:  begin do_push = 1'b1; push_val = W'(a_val != b_val); end
            sbe_pkg::OP_LAND: begin
                do_push = 1'b1; push_val = W'((a_val != '0) && (b_val != '0));
            end
            sbe_pkg::OP_LOR: begin
                do_push = 1'b1; push_val = W'((a_val != '0) || (b_val != '0));
            end
            sbe_pkg::OP_NEG:  begin do_push = 1'b1; push_val = '0 - a_val; end
            sbe_pkg::OP_LNOT: begin do_push = 1'b1; push_val = W'(a_val == '0); end
            sbe_pkg::OP_BNOT: begin do_push = 1'b1; push_val = ~a_val; end
            sbe_pkg::OP_SAY: begin
                res.emit_kind = sbe_pkg::EK_SAY; res.emit_value = a_val;
            end
            sbe_pkg::OP_FEEL: begin
                res.emit_kind  = sbe_pkg::EK_FEEL;
                res.emit_value = {32'd0, r_imm[31:0]};
            end
            sbe_pkg::OP_RET, sbe_pkg::OP_HALT: res.status = sbe_pkg::ST_HALT;
            sbe_pkg::OP_JIF: res.branch_taken = (a_val == '0);
            sbe_pkg::OP_JMP: res.branch_taken = 1'b1;
            default: res.status = sbe_pkg::ST_BADOP;
        endcase
    end

    // final execute cycle: operand in hand and result register free
    logic out_load;
    assign out_load = (r_state == S_EXEC) && !(!is_bin && r_npop == 2'd1)
                      && (!r_out_v || o_result.ready);

    logic push_ok;
    assign push_ok   = do_push && (32'(r_depth) < eff_lim);
    assign mem_we    = out_load && push_ok;
    assign mem_waddr = r_depth[AW-1:0];
    assign mem_wdata = push_val;

    assign i_instr.ready    = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_result.valid   = r_out_v;
    assign o_result.payload = r_out;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_limit <= sbe_pkg::LimitReset;
            r_out_v <= 1'b0;
            r_npop  <= '0;
            r_hasa  <= 1'b0;
            r_hasb  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && o_result.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_instr.valid) begin
                        r_op    <= i_instr.payload.opcode;
                        r_imm   <= i_instr.payload.immediate;
                        r_hasa  <= 1'b0;
                        r_hasb  <= 1'b0;
                        r_state <= S_POPB;
                    end
                end
                S_POPB: begin
                    // issue first pop (b for binary, a for unary)
                    if ((is_bin || is_un) && r_depth != '0) begin
                        r_depth <= dm1;
                        r_npop  <= 2'd1;
                    end else begin
                        r_npop  <= 2'd0;
                    end
                    r_state <= is_bin ? S_POPA : S_EXEC;
                end
                S_POPA: begin
                    // capture b, issue pop for a
                    if (r_npop == 2'd1) begin
                        r_b <= r_rdata; r_hasb <= 1'b1;
                    end
                    if (r_depth != '0) begin
                        r_depth <= dm1;
                        r_npop  <= 2'd1;
                    end else begin
                        r_npop  <= 2'd0;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // capture a; start mul or div
                    if (r_npop == 2'd1) begin
                        r_a <= r_rdata; r_hasa <= 1'b1;
                    end
                    r_npop <= 2'd0;
                    r_cnt  <= '0;
                    if (r_op == sbe_pkg::OP_DIV || r_op == sbe_pkg::OP_MOD) begin
                        r_quo   <= (r_npop == 2'd1) ? r_rdata : '0;
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else if (r_op == sbe_pkg::OP_MUL) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_DONE: begin
                    // accumulate lo*lo, then both cross terms shifted up
                    r_prod  <= (r_cnt == 7'd0) ? mul_p
                                               : r_prod + {mul_p[HW-1:0], {HW{1'b0}}};
                    r_cnt   <= r_cnt + 7'd1;
                    if (r_cnt == 7'd2) r_state <= S_EXEC;
                end
                S_DIV: begin
                    // restoring divide, one bit per cycle
                    r_rem <= rem_ge ? W'(rem_sh - {1'b0, b_val}) : rem_sh[W-1:0];
                    r_quo <= {r_quo[W-2:0], rem_ge};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(W - 1)) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    // unary path captures its operand here
                    if (!is_bin && r_npop == 2'd1) begin
                        r_a <= r_rdata; r_hasa <= 1'b1;
                        r_npop <= 2'd0;
                    end else if (out_load) begin
                        if (push_ok) r_depth <= r_depth + DW'(1);
                        r_out   <= res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### verif/tb_stack_bytecode_executor.sv
`timescale 1ns / 1ps
module tb_stack_bytecode_executor;

    localparam int unsigned StackCap   = 1024;
    localparam int unsigned IdleLimit  = 20000;
    localparam int unsigned RandItems  = 1000;
    localparam int unsigned DrainWait  = 200;

    logic i_clk;
    logic i_rst_n;

    sbe_instr_if  instr_ch ();
    sbe_result_if result_ch ();
    sbe_cfg_if    cfg_ch ();

    stack_bytecode_executor dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch.sink),
        .o_result (result_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // shadow machine state
    logic [63:0]                shadow_stack [StackCap];
    int unsigned                shadow_depth;
    logic [sbe_pkg::LimitW-1:0] shadow_limit;

    sbe_pkg::t_result pending_results [$];
    int unsigned fail_count;
    int unsigned result_count;
    int unsigned idle_cycles;
    bit          rx_stall_en;
    bit          rx_hold_req;
    int unsigned rx_hold_cycles;

    function automatic int unsigned push_room();
        int unsigned lim;
        lim = (shadow_limit < StackCap) ? shadow_limit : StackCap;
        return lim;
    endfunction

    function automatic void shadow_push(logic [63:0] v);
        if (shadow_depth < push_room()) begin
            shadow_stack[shadow_depth] = v;
            shadow_depth++;
        end
    endfunction

    function automatic logic [63:0] shadow_pop();
        if (shadow_depth == 0) return 64'd0;
        shadow_depth--;
        return shadow_stack[shadow_depth];
    endfunction

    // executes one instruction on the shadow stack, returns its result
    function automatic sbe_pkg::t_result exec_instr(sbe_pkg::t_instr ins);
        sbe_pkg::t_result r;
        logic [63:0] a, b;
        r = '0;
        if (ins.opcode >= sbe_pkg::OP_ADD && ins.opcode <= sbe_pkg::OP_LOR) begin
            b = shadow_pop();
            a = shadow_pop();
            case (sbe_pkg::t_opcode'(ins.opcode))
                sbe_pkg::OP_ADD: shadow_push(a + b);
                sbe_pkg::OP_SUB: shadow_push(a - b);
                sbe_pkg::OP_MUL: shadow_push(a * b);
                sbe_pkg::OP_DIV: begin
                    if (b == 0) r.status = sbe_pkg::ST_DIV0;
                    else shadow_push(a / b);
                end
                sbe_pkg::OP_MOD: begin
                    if (b == 0) r.status = sbe_pkg::ST_DIV0;
                    else shadow_push(a % b);
                end
                sbe_pkg::OP_LT:   shadow_push({63'd0, a < b});
                sbe_pkg::OP_GT:   shadow_push({63'd0, a > b});
                sbe_pkg::OP_EQ:   shadow_push({63'd0, a == b});
                sbe_pkg::OP_NEQ:  shadow_push({63'd0, a != b});
                sbe_pkg::OP_LAND: shadow_push({63'd0, (a != 0) && (b != 0)});
                default: shadow_push({63'd0, (a != 0) || (b != 0)});
            endcase
        end else begin
            case (ins.opcode)
                sbe_pkg::OP_PUSH, sbe_pkg::OP_LDVAR: shadow_push(ins.immediate);
                sbe_pkg::OP_LDSTR: ;
                sbe_pkg::OP_STVAR: begin
                    r.emit_kind  = sbe_pkg::EK_STORE;
                    r.emit_value = shadow_pop();
                end
                sbe_pkg::OP_NEG:  shadow_push(64'd0 - shadow_pop());
                sbe_pkg::OP_LNOT: shadow_push({63'd0, shadow_pop() == 0});
                sbe_pkg::OP_BNOT: shadow_push(~shadow_pop());
                sbe_pkg::OP_SAY: begin
                    r.emit_kind  = sbe_pkg::EK_SAY;
                    r.emit_value = shadow_pop();
                end
                sbe_pkg::OP_FEEL: begin
                    r.emit_kind  = sbe_pkg::EK_FEEL;
                    r.emit_value = {32'd0, ins.immediate[31:0]};
                end
                sbe_pkg::OP_RET, sbe_pkg::OP_HALT: r.status = sbe_pkg::ST_HALT;
                sbe_pkg::OP_JIF: r.branch_taken = (shadow_pop() == 0);
                sbe_pkg::OP_JMP: r.branch_taken = 1'b1;
                default: r.status = sbe_pkg::ST_BADOP;
            endcase
        end
        return r;
    endfunction

    // drive one instruction, with random gaps when enabled
    task automatic send_instr(logic [7:0] op, logic [63:0] imm, bit gaps);
        sbe_pkg::t_instr ins;
        ins.opcode    = op;
        ins.immediate = imm;
        if (gaps && $urandom_range(3) == 0) begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        instr_ch.valid   <= 1'b1;
        instr_ch.payload <= ins;
        do @(posedge i_clk); while (!instr_ch.ready);
        pending_results.push_back(exec_instr(ins));
    endtask

    task automatic end_burst();
        instr_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [sbe_pkg::LimitW-1:0] lim);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= lim;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        shadow_limit = lim;
    endtask

    // receiver: random stalls, plus a long hold on request
    initial begin
        result_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold_req) begin
                result_ch.ready <= 1'b0;
                rx_hold_cycles = 0;
                while (rx_hold_cycles < 300) begin
                    @(posedge i_clk);
                    rx_hold_cycles++;
                end
                rx_hold_req = 1'b0;
            end else if (rx_stall_en && $urandom_range(7) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            sbe_pkg::t_result exp_r;
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result exp none got %h", $time,
                         result_ch.payload);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (result_ch.payload.status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                             result_ch.payload.status);
                    fail_count++;
                end
                if (result_ch.payload.emit_kind !== exp_r.emit_kind) begin
                    $display("%0t: emit_kind exp %0d got %0d", $time, exp_r.emit_kind,
                             result_ch.payload.emit_kind);
                    fail_count++;
                end
                if (result_ch.payload.emit_value !== exp_r.emit_value) begin
                    $display("%0t: emit_value exp %h got %h", $time, exp_r.emit_value,
                             result_ch.payload.emit_value);
                    fail_count++;
                end
                if (result_ch.payload.branch_taken !== exp_r.branch_taken) begin
                    $display("%0t: branch_taken exp %b got %b", $time, exp_r.branch_taken,
                             result_ch.payload.branch_taken);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: timeout", $time);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // directed table: opcode, immediate, check flag, expected result
    typedef struct {
        logic [7:0]       op;
        logic [63:0]      imm;
        bit               typed;
        sbe_pkg::t_result exp_r;
    } t_row;

    t_row dir_rows [$];

    function automatic sbe_pkg::t_result mk(logic [1:0] st, logic [1:0] ek,
                                            logic [63:0] v, bit br);
        sbe_pkg::t_result r;
        r.status = st;
        r.emit_kind = ek;
        r.emit_value = v;
        r.branch_taken = br;
        return r;
    endfunction

    function automatic void add_row(logic [7:0] op, logic [63:0] imm, bit typed,
                                    sbe_pkg::t_result r);
        t_row row;
        row.op = op;
        row.imm = imm;
        row.typed = typed;
        row.exp_r = r;
        dir_rows.push_back(row);
    endfunction

    // random opcode, mostly valid operations
    function automatic logic [7:0] rand_op(int unsigned depth_now);
        logic [7:0] ops [24];
        int unsigned k;
        ops = '{sbe_pkg::OP_PUSH, sbe_pkg::OP_LDSTR, sbe_pkg::OP_LDVAR,
                sbe_pkg::OP_STVAR, sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL,
                sbe_pkg::OP_DIV, sbe_pkg::OP_MOD, sbe_pkg::OP_LT, sbe_pkg::OP_GT,
                sbe_pkg::OP_EQ, sbe_pkg::OP_NEQ, sbe_pkg::OP_LAND, sbe_pkg::OP_LOR,
                sbe_pkg::OP_NEG, sbe_pkg::OP_LNOT, sbe_pkg::OP_BNOT, sbe_pkg::OP_SAY,
                sbe_pkg::OP_FEEL, sbe_pkg::OP_RET, sbe_pkg::OP_JIF, sbe_pkg::OP_JMP,
                sbe_pkg::OP_HALT};
        k = $urandom_range(99);
        if (k < 5) return 8'($urandom_range(255));
        if (k < 40 && depth_now < 6) return sbe_pkg::OP_PUSH;
        return ops[$urandom_range(23)];
    endfunction

    function automatic logic [63:0] rand_val();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return {64{1'b1}};
            2: return 64'($urandom_range(7));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [sbe_pkg::LimitW-1:0] limits [6];
        t_row row;
        sbe_pkg::t_result got;
        int unsigned n;
        fail_count = 0;
        result_count = 0;
        idle_cycles = 0;
        rx_stall_en = 1'b0;
        rx_hold_req = 1'b0;
        instr_ch.valid = 1'b0;
        instr_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        shadow_depth = 0;
        shadow_limit = sbe_pkg::LimitReset;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty stack, extremes, a subset of opcodes, errors
        add_row(sbe_pkg::OP_SAY, 64'd0, 1'b1,
                mk(sbe_pkg::ST_CONT, sbe_pkg::EK_SAY, 64'd0, 1'b0));
        add_row(sbe_pkg::OP_JIF, 64'd0, 1'b1,
                mk(sbe_pkg::ST_CONT, sbe_pkg::EK_NONE, 64'd0, 1'b1));
        add_row(sbe_pkg::OP_DIV, 64'd0, 1'b1,
                mk(sbe_pkg::ST_DIV0, sbe_pkg::EK_NONE, 64'd0, 1'b0));
        add_row(sbe_pkg::OP_PUSH, {64{1'b1}}, 1'b1,
                mk(sbe_pkg::ST_CONT, sbe_pkg::EK_NONE, 64'd0, 1'b0));
        add_row(sbe_pkg::OP_STVAR, 64'd0, 1'b1,
                mk(sbe_pkg::ST_CONT, sbe_pkg::EK_STORE, {64{1'b1}}, 1'b0));
        add_row(sbe_pkg::OP_FEEL, {64{1'b1}}, 1'b1,
                mk(sbe_pkg::ST_CONT, sbe_pkg::EK_FEEL, 64'hFFFF_FFFF, 1'b0));
        add_row(sbe_pkg::OP_HALT, 64'd0, 1'b1,
                mk(sbe_pkg::ST_HALT, sbe_pkg::EK_NONE, 64'd0, 1'b0));
        add_row(sbe_pkg::OP_RET, 64'd0, 1'b1,
                mk(sbe_pkg::ST_HALT, sbe_pkg::EK_NONE, 64'd0, 1'b0));
        add_row(sbe_pkg::OP_JMP, 64'd0, 1'b1,
                mk(sbe_pkg::ST_CONT, sbe_pkg::EK_NONE, 64'd0, 1'b1));
        add_row(8'h00, 64'd5, 1'b1,
                mk(sbe_pkg::ST_BADOP, sbe_pkg::EK_NONE, 64'd0, 1'b0));
        add_row(8'hFE, 64'd5, 1'b1,
                mk(sbe_pkg::ST_BADOP, sbe_pkg::EK_NONE, 64'd0, 1'b0));
        add_row(sbe_pkg::OP_LDSTR, 64'd9, 1'b1,
                mk(sbe_pkg::ST_CONT, sbe_pkg::EK_NONE, 64'd0, 1'b0));
        add_row(sbe_pkg::OP_LDVAR, 64'h8000_0000_0000_0000, 1'b0, '0);
        add_row(sbe_pkg::OP_PUSH,  64'd0, 1'b0, '0);
        add_row(sbe_pkg::OP_MOD, 64'd0, 1'b1,
                mk(sbe_pkg::ST_DIV0, sbe_pkg::EK_NONE, 64'd0, 1'b0));
        add_row(sbe_pkg::OP_PUSH,  64'd7, 1'b0, '0);
        add_row(sbe_pkg::OP_NEG,   64'd0, 1'b0, '0);
        add_row(sbe_pkg::OP_BNOT,  64'd0, 1'b0, '0);
        add_row(sbe_pkg::OP_LNOT,  64'd0, 1'b0, '0);
        add_row(sbe_pkg::OP_PUSH,  64'd3, 1'b0, '0);
        add_row(sbe_pkg::OP_MUL,   64'd0, 1'b0, '0);
        add_row(sbe_pkg::OP_PUSH,  64'd0, 1'b0, '0);
        add_row(sbe_pkg::OP_LT,    64'd0, 1'b0, '0);
        add_row(sbe_pkg::OP_SAY,   64'd0, 1'b0, '0);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_instr(row.op, row.imm, 1'b0);
            if (row.typed) begin
                got = pending_results[$];
                if (got != row.exp_r) begin
                    $display("%0t: directed row %0d exp %h model %h", $time, i,
                             row.exp_r, got);
                    fail_count++;
                end
            end
        end
        end_burst();
        wait_drained();

        // fill to a small limit with the receiver held off
        write_limit(11'd3);
        rx_hold_req = 1'b1;
        for (int i = 0; i < 6; i++) send_instr(sbe_pkg::OP_PUSH, rand_val(), 1'b0);
        for (int i = 0; i < 4; i++) send_instr(sbe_pkg::OP_SAY, 64'd0, 1'b0);
        end_burst();
        wait_drained();

        // random phases over several limits, last phase without idling
        limits = '{11'd0, 11'd1, 11'd2, 11'd2047, 11'd5, 11'd1024};
        rx_stall_en = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(limits[ph]);
            if (ph == 5) rx_stall_en = 1'b0;
            n = (ph == 5) ? 300 : RandItems / 7;
            for (int i = 0; i < n; i++)
                send_instr(rand_op(shadow_depth), rand_val(), ph != 5);
            end_burst();
            wait_drained();
        end
        // lower the limit below the current depth
        write_limit(11'd1);
        for (int i = 0; i < 4; i++) send_instr(sbe_pkg::OP_PUSH, rand_val(), 1'b0);
        send_instr(sbe_pkg::OP_SAY, 64'd0, 1'b0);
        send_instr(sbe_pkg::OP_SAY, 64'd0, 1'b0);
        end_burst();
        wait_drained();
        repeat (DrainWait) @(posedge i_clk);

        $display("Covered %0d results: every opcode, empty/full stack, zero divisor,",
                 result_count);
        $display("bad opcodes and stack limits 0 to 2047 with stalls on both sides.");
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
